FILE: hw/rtl/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix frame store package
// Shared types and constants for the frame store, the sequencer and the top.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 24;
  localparam int FRAME_HEIGHT = 16;

  // The store is kept as 16-bit words, each holding two consecutive bytes:
  // the earlier byte in the high half.
  localparam int STORE_BYTES = 48;
  localparam int STORE_WORDS = STORE_BYTES / 2;
  localparam int WORD_AW     = $clog2(STORE_WORDS);

  // Words sent on a flush.
  localparam int FRAME_BYTES = FRAME_WIDTH * FRAME_HEIGHT / 8;
  localparam int FLUSH_RAW   = (FRAME_BYTES + 1) / 2;
  localparam int FLUSH_WORDS = (FLUSH_RAW > STORE_WORDS) ? STORE_WORDS : FLUSH_RAW;

  // Field widths.
  localparam int CODE_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 5;

  // Bit counts of the emitted words.
  localparam logic [COUNT_W-1:0] CNT_CODE = 5'd3;
  localparam logic [COUNT_W-1:0] CNT_ADDR = 5'd7;
  localparam logic [COUNT_W-1:0] CNT_CMD  = 5'd12;
  localparam logic [COUNT_W-1:0] CNT_DATA = 5'd16;

  // Register reset values.
  localparam logic [CODE_W-1:0] WRITE_CODE_RST   = 3'd5;
  localparam logic [CODE_W-1:0] COMMAND_CODE_RST = 3'd4;

  typedef enum logic [1:0] {
    ACT_DRAW    = 2'd0,
    ACT_FLUSH   = 2'd1,
    ACT_COMMAND = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRITE_CODE   = 2'd0,
    REG_COMMAND_CODE = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
    logic [7:0] command_byte;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  serial_word;
    logic [COUNT_W-1:0] bit_count;
    logic               last;
  } result_t;

  // Access request from the sequencer to the frame memory.
  typedef struct packed {
    logic               re;
    logic [WORD_AW-1:0] raddr;
    logic               we;
    logic [WORD_AW-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
  } ram_req_t;

endpackage

FILE: hw/rtl/lmfs_frame_ram.sv
// ----------------------------------------------------------------------------
// LED matrix frame memory
// One write and one read port, registered read; entries read as zero until
// first written.
// ----------------------------------------------------------------------------
module lmfs_frame_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lmfs_pkg::ram_req_t            req_i,
  output logic [lmfs_pkg::WORD_W-1:0]   rdata_o
);
  import lmfs_pkg::*;

  logic [WORD_W-1:0]      mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] valid_q;
  logic [WORD_W-1:0]      rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // The blank screen after reset comes from the valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

FILE: hw/rtl/lmfs_seq.sv
// ----------------------------------------------------------------------------
// LED matrix sequencer
// Runs pixel read-modify-write, the flush stream and command words.
// ----------------------------------------------------------------------------
module lmfs_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  lmfs_pkg::in_item_t            item_i,
  input  logic [lmfs_pkg::CODE_W-1:0]   write_code_i,
  input  logic [lmfs_pkg::CODE_W-1:0]   command_code_i,
  input  logic [lmfs_pkg::WORD_W-1:0]   rdata_i,
  output lmfs_pkg::ram_req_t            req_o,
  output logic                          busy_o,
  output logic                          strobe_o,
  output lmfs_pkg::result_t             result_o
);
  import lmfs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMW  = 3'd1;
  localparam logic [2:0] ST_CODE = 3'd2;
  localparam logic [2:0] ST_ADDR = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_CMD  = 3'd5;

  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(FLUSH_WORDS - 1);

  logic [2:0]         state_q, state_d;
  logic [WORD_AW-1:0] cnt_q, cnt_d;
  logic [WORD_AW-1:0] paddr_q, paddr_d;
  logic [3:0]         pbit_q, pbit_d;
  logic               pon_q, pon_d;
  logic [7:0]         cmd_q, cmd_d;
  logic               in_frame;
  logic [WORD_W-1:0]  mask;

  // Pixel mapping: byte index is {x[4:3], y[2:0], y[3]}, so the word is
  // {x[4:3], y[2:0]}; rows 8..15 land in the low byte, and the column counts
  // down from bit 7 of its byte.
  assign in_frame = (item_i.pixel_x < 8'(FRAME_WIDTH)) &&
                    (item_i.pixel_y < 8'(FRAME_HEIGHT));
  assign mask = WORD_W'(1) << pbit_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    paddr_d  = paddr_q;
    pbit_d   = pbit_q;
    pon_d    = pon_q;
    cmd_d    = cmd_q;
    req_o    = '0;
    strobe_o = 1'b0;
    result_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          case (action_e'(item_i.action))
            ACT_DRAW: begin
              if (in_frame) begin
                paddr_d   = {item_i.pixel_x[4:3], item_i.pixel_y[2:0]};
                pbit_d    = {~item_i.pixel_y[3], ~item_i.pixel_x[2:0]};
                pon_d     = item_i.pixel_on;
                req_o.re    = 1'b1;
                req_o.raddr = {item_i.pixel_x[4:3], item_i.pixel_y[2:0]};
                state_d   = ST_RMW;
              end
            end
            ACT_FLUSH: begin
              state_d = ST_CODE;
            end
            ACT_COMMAND: begin
              cmd_d   = item_i.command_byte;
              state_d = ST_CMD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RMW: begin
        req_o.we    = 1'b1;
        req_o.waddr = paddr_q;
        req_o.wdata = pon_q ? (rdata_i | mask) : (rdata_i & ~mask);
        state_d     = ST_IDLE;
      end
      ST_CODE: begin
        strobe_o             = 1'b1;
        result_o.serial_word = WORD_W'(write_code_i);
        result_o.bit_count   = CNT_CODE;
        state_d              = ST_ADDR;
      end
      ST_ADDR: begin
        strobe_o           = 1'b1;
        result_o.bit_count = CNT_ADDR;
        req_o.re           = 1'b1;
        req_o.raddr        = '0;
        cnt_d              = '0;
        state_d            = ST_DATA;
      end
      ST_DATA: begin
        strobe_o             = 1'b1;
        result_o.serial_word = rdata_i;
        result_o.bit_count   = CNT_DATA;
        result_o.last        = (cnt_q == LAST_WORD);
        if (cnt_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end else begin
          req_o.re    = 1'b1;
          req_o.raddr = cnt_q + 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      ST_CMD: begin
        strobe_o             = 1'b1;
        result_o.serial_word = WORD_W'({command_code_i, cmd_q, 1'b0});
        result_o.bit_count   = CNT_CMD;
        result_o.last        = 1'b1;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    pbit_q  <= pbit_d;
    pon_q   <= pon_d;
    cmd_q   <= cmd_d;
  end

endmodule

FILE: hw/rtl/led_matrix_frame_store_serializer.sv
// ----------------------------------------------------------------------------
// LED matrix frame store and serializer
// 24x16 one-bit frame store with flush and command word generation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A pixel draw
// reads and writes back one word of the frame memory and gives no
// result; draws outside the frame and the unused action code change
// nothing. A command gives one 12-bit word in the cycle
// after acceptance. A flush gives the write code, a zero address and then
// one 16-bit frame word per cycle from the memory read port, 2 + 24 results
// in consecutive cycles, then busy falls. Each result is shown for exactly
// one cycle with out_strobe_o high; the receiver must take it then, since
// the block does not wait. The store reads as blank after reset with no
// clearing pass. Configuration writes are always accepted and should be
// made only while busy is low.
module led_matrix_frame_store_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  lmfs_pkg::in_item_t              item_i,
  output logic                            out_strobe_o,
  output lmfs_pkg::result_t               result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lmfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lmfs_pkg::CODE_W-1:0]     cfg_data_i
);
  import lmfs_pkg::*;

  logic [CODE_W-1:0] write_code_q;
  logic [CODE_W-1:0] command_code_q;
  logic              cfg_we;
  logic              accept;
  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign accept      = start & ~busy;

  // Mode code registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_code_q   <= WRITE_CODE_RST;
      command_code_q <= COMMAND_CODE_RST;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WRITE_CODE:   write_code_q   <= cfg_data_i;
        REG_COMMAND_CODE: command_code_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lmfs_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .write_code_i   (write_code_q),
    .command_code_i (command_code_q),
    .rdata_i        (ram_rdata),
    .req_o          (ram_req),
    .busy_o         (busy),
    .strobe_o       (out_strobe_o),
    .result_o       (result_o)
  );

  lmfs_frame_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule
